/* src/tlp_pkg.sv */
// ----------------------------------------------------------------------------
// tlp_pkg: timestamp line parser shared definitions
// Types, constants and small helper functions used by the parser modules.
// ----------------------------------------------------------------------------
package tlp_pkg;

  localparam int unsigned LineLength = 17;
  localparam int unsigned CountWidth = $clog2(LineLength + 1);

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam logic [7:0] HourMax   = 8'd23;
  localparam logic [7:0] MinSecMax = 8'd59;
  localparam logic [7:0] DayMax    = 8'd31;
  localparam logic [7:0] MonthMax  = 8'd12;
  localparam logic [7:0] YearMax   = 8'd99;

  // field start positions within the line
  localparam int unsigned PosHour   = 0;
  localparam int unsigned PosMinute = 3;
  localparam int unsigned PosSecond = 6;
  localparam int unsigned PosDay    = 9;
  localparam int unsigned PosMonth  = 12;
  localparam int unsigned PosYear   = 15;

  // separator positions
  localparam int unsigned PosSepHm  = 2;
  localparam int unsigned PosSepMs  = 5;
  localparam int unsigned PosSepTd  = 8;
  localparam int unsigned PosSepDm  = 11;
  localparam int unsigned PosSepMy  = 14;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_FORMAT = 2'd2
  } status_e;

  typedef logic [LineLength-1:0][7:0] line_t;

  // snapshot of the line store handed to the checker
  typedef struct packed {
    line_t chars;
    logic  full;
  } store_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] second_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] day_bcd;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
  } result_t;

  // (hi - '0') * 10 + (lo - '0'), wrapped to 8 bits
  function automatic logic [7:0] two_digit(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    begin
      h = hi - CharZero;
      l = lo - CharZero;
      two_digit = (h << 3) + (h << 1) + l;
    end
  endfunction

  // binary to two BCD digits, argument below 100
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    begin
      prod   = {8'd0, v} * 16'd205;
      tens   = prod[14:11];
      ones   = v - ({4'd0, tens} << 3) - ({4'd0, tens} << 1);
      to_bcd = {tens, ones[3:0]};
    end
  endfunction

endpackage

/* src/tlp_if.sv */
// ----------------------------------------------------------------------------
// tlp channel interfaces
// Valid/ready channels for received bytes and for parse results.
// ----------------------------------------------------------------------------
interface tlp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] second_bcd;
  logic [7:0] minute_bcd;
  logic [7:0] hour_bcd;
  logic [7:0] day_bcd;
  logic [7:0] month_bcd;
  logic [7:0] year_bcd;

  modport source (output valid, output status, output second_bcd, output minute_bcd,
                  output hour_bcd, output day_bcd, output month_bcd, output year_bcd,
                  input ready);
  modport sink   (input valid, input status, input second_bcd, input minute_bcd,
                  input hour_bcd, input day_bcd, input month_bcd, input year_bcd,
                  output ready);
endinterface

/* src/tlp_line_store.sv */
// ----------------------------------------------------------------------------
// tlp_line_store: received character store
// Holds the characters of the current line and the saturating fill count.
// ----------------------------------------------------------------------------
module tlp_line_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            beat_i,
  input  logic [7:0]      rx_byte_i,
  output tlp_pkg::store_t store_o
);

  logic [tlp_pkg::CountWidth-1:0] count_q, count_d;
  tlp_pkg::line_t                 chars_q;
  logic                           is_cr;
  logic                           full;
  logic                           wr_en;

  assign is_cr = (rx_byte_i == tlp_pkg::CharCr);
  assign full  = (count_q == tlp_pkg::CountWidth'(tlp_pkg::LineLength));
  assign wr_en = beat_i && !is_cr && !full;

  always_comb begin
    count_d = count_q;
    if (beat_i) begin
      if (is_cr) begin
        count_d = '0;
      end else if (!full) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // payload only, contents read once the line is full
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      chars_q[count_q] <= rx_byte_i;
    end
  end

  assign store_o.chars = chars_q;
  assign store_o.full  = full;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tlp_pkg::CountWidth'(tlp_pkg::LineLength))
    else $error("line count beyond line length");

  a_cr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i && is_cr) |=> (count_q == '0))
    else $error("count not cleared after carriage return");

endmodule

/* src/tlp_field_check.sv */
// ----------------------------------------------------------------------------
// tlp_field_check: line decode and check
// Forms the six two-digit values, checks ranges then separators, builds BCD.
// ----------------------------------------------------------------------------
module tlp_field_check (
  input  tlp_pkg::store_t  store_i,
  output tlp_pkg::result_t result_o
);

  logic [7:0] hour, minute, second, day, month, year;
  logic       range_bad;
  logic       sep_bad;
  tlp_pkg::line_t ch;

  assign ch = store_i.chars;

  assign hour   = tlp_pkg::two_digit(ch[tlp_pkg::PosHour],   ch[tlp_pkg::PosHour + 1]);
  assign minute = tlp_pkg::two_digit(ch[tlp_pkg::PosMinute], ch[tlp_pkg::PosMinute + 1]);
  assign second = tlp_pkg::two_digit(ch[tlp_pkg::PosSecond], ch[tlp_pkg::PosSecond + 1]);
  assign day    = tlp_pkg::two_digit(ch[tlp_pkg::PosDay],    ch[tlp_pkg::PosDay + 1]);
  assign month  = tlp_pkg::two_digit(ch[tlp_pkg::PosMonth],  ch[tlp_pkg::PosMonth + 1]);
  assign year   = tlp_pkg::two_digit(ch[tlp_pkg::PosYear],   ch[tlp_pkg::PosYear + 1]);

  assign range_bad = (hour > tlp_pkg::HourMax) || (minute > tlp_pkg::MinSecMax) ||
                     (second > tlp_pkg::MinSecMax) || (day == 8'd0) ||
                     (day > tlp_pkg::DayMax) || (month == 8'd0) ||
                     (month > tlp_pkg::MonthMax) || (year > tlp_pkg::YearMax);

  assign sep_bad = (ch[tlp_pkg::PosSepHm] != tlp_pkg::CharColon) ||
                   (ch[tlp_pkg::PosSepMs] != tlp_pkg::CharColon) ||
                   (ch[tlp_pkg::PosSepTd] != tlp_pkg::CharSpace) ||
                   (ch[tlp_pkg::PosSepDm] != tlp_pkg::CharSlash) ||
                   (ch[tlp_pkg::PosSepMy] != tlp_pkg::CharSlash);

  always_comb begin
    result_o = '0;
    priority if (!store_i.full) begin
      // short line, no value check
      result_o.status = tlp_pkg::STATUS_FORMAT;
    end else if (range_bad) begin
      result_o.status = tlp_pkg::STATUS_RANGE;
    end else if (sep_bad) begin
      result_o.status = tlp_pkg::STATUS_FORMAT;
    end else begin
      result_o.status     = tlp_pkg::STATUS_OK;
      result_o.second_bcd = tlp_pkg::to_bcd(second);
      result_o.minute_bcd = tlp_pkg::to_bcd(minute);
      result_o.hour_bcd   = tlp_pkg::to_bcd(hour);
      result_o.day_bcd    = tlp_pkg::to_bcd(day);
      result_o.month_bcd  = tlp_pkg::to_bcd(month);
      result_o.year_bcd   = tlp_pkg::to_bcd(year);
    end
  end

endmodule

/* src/timestamp_line_parser.sv */
// ----------------------------------------------------------------------------
// timestamp_line_parser: "HH:MM:SS DD/MM/YY" line parser
// Collects a line of received characters and reports status and BCD fields
// at each carriage return.
// ----------------------------------------------------------------------------
// result: registered at its carriage return beat and valid in the next cycle
// throughput: one byte per cycle; the result register frees as it is taken, so
//   a full register accepts the next byte only with ready high
// reset: clears the character count and the result valid; the line store
//   is not reset, its contents are read only after a full line is written
module timestamp_line_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  tlp_rx_if.sink          rx_i,
  tlp_res_if.source       res_o
);

  logic             rx_beat;
  logic             cr_beat;
  logic             res_valid_q, res_valid_d;
  tlp_pkg::store_t  store;
  tlp_pkg::result_t result_d, result_q;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign rx_beat    = rx_i.valid && rx_i.ready;
  assign cr_beat    = rx_beat && (rx_i.rx_byte == tlp_pkg::CharCr);

  tlp_line_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (rx_beat),
    .rx_byte_i (rx_i.rx_byte),
    .store_o   (store)
  );

  tlp_field_check u_check (
    .store_i  (store),
    .result_o (result_d)
  );

  always_comb begin
    res_valid_d = res_valid_q;
    if (cr_beat) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cr_beat) begin
      result_q <= result_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.status     = result_q.status;
  assign res_o.second_bcd = result_q.second_bcd;
  assign res_o.minute_bcd = result_q.minute_bcd;
  assign res_o.hour_bcd   = result_q.hour_bcd;
  assign res_o.day_bcd    = result_q.day_bcd;
  assign res_o.month_bcd  = result_q.month_bcd;
  assign res_o.year_bcd   = result_q.year_bcd;

  a_cr_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_beat |=> res_valid_q)
    else $error("no result after carriage return");

  a_no_beat_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |-> !rx_beat)
    else $error("byte taken while result register blocked");

  a_fields_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (result_q.status != tlp_pkg::STATUS_OK)) |->
      (result_q.second_bcd == 8'd0 && result_q.minute_bcd == 8'd0 &&
       result_q.hour_bcd == 8'd0 && result_q.day_bcd == 8'd0 &&
       result_q.month_bcd == 8'd0 && result_q.year_bcd == 8'd0))
    else $error("fields nonzero on rejected line");

  a_bcd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (result_q.status == tlp_pkg::STATUS_OK)) |->
      (result_q.hour_bcd <= 8'h23 && result_q.minute_bcd <= 8'h59 &&
       result_q.second_bcd <= 8'h59 && result_q.day_bcd != 8'h00 &&
       result_q.day_bcd <= 8'h31 && result_q.month_bcd != 8'h00 &&
       result_q.month_bcd <= 8'h12 && result_q.year_bcd[3:0] <= 4'd9))
    else $error("accepted field out of range");

endmodule
